>>> src/gmlp_pkg.sv
// ----------------------------------------------------------------------------
// gmlp_pkg
// Shared types, character codes and constants of the G-code move line parser.
// ----------------------------------------------------------------------------
package gmlp_pkg;

  localparam int unsigned FRAC_MAX    = 6;
  localparam int unsigned POW_W       = 20;
  localparam int unsigned MAG_W       = 31;
  localparam logic [MAG_W-1:0] MAG_MAX = 31'h7FFF_FFFF;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;

  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_LINEAR = 2'd1;
  localparam logic [1:0] CMD_HOME   = 2'd2;

  localparam logic [6:0] G_LINEAR = 7'd1;
  localparam logic [6:0] G_HOME   = 7'd28;
  localparam logic [6:0] G_MAX    = 7'd127;

  typedef enum logic [2:0] {
    TK_OTHER,
    TK_DIGIT,
    TK_MINUS,
    TK_DOT,
    TK_EOL,
    TK_G,
    TK_X,
    TK_Y
  } token_kind_e;

  typedef struct packed {
    token_kind_e kind;
    logic [3:0]  digit;
  } token_t;

  function automatic logic [POW_W-1:0] pow10(input logic [2:0] k);
    logic [POW_W-1:0] r;
    case (k)
      3'd0:    r = 20'd1;
      3'd1:    r = 20'd10;
      3'd2:    r = 20'd100;
      3'd3:    r = 20'd1000;
      3'd4:    r = 20'd10000;
      3'd5:    r = 20'd100000;
      default: r = 20'd1000000;
    endcase
    return r;
  endfunction

endpackage

>>> src/gmlp_if.sv
// ----------------------------------------------------------------------------
// gmlp_char_if / gmlp_cmd_if
// Valid/ready channels for input characters and parsed command results.
// ----------------------------------------------------------------------------
interface gmlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface gmlp_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command_type;
  logic               unknown_g;
  logic signed [31:0] x_position;
  logic               x_present;
  logic signed [31:0] y_position;
  logic               y_present;

  modport source (output valid, output command_type, output unknown_g,
                  output x_position, output x_present,
                  output y_position, output y_present, input ready);
  modport sink   (input valid, input command_type, input unknown_g,
                  input x_position, input x_present,
                  input y_position, input y_present, output ready);
endinterface

>>> src/gmlp_front.sv
// ----------------------------------------------------------------------------
// gmlp_front
// Accepts characters and classifies each one into a token for the queue.
// ----------------------------------------------------------------------------
module gmlp_front (
  gmlp_char_if.sink         char_i,
  output logic              tok_valid_o,
  output gmlp_pkg::token_t  tok_o,
  input  logic              tok_ready_i
);
  import gmlp_pkg::*;

  always_comb begin
    tok_o.digit = 4'd0;
    case (char_i.character) inside
      CH_NUL:       tok_o.kind = TK_EOL;
      [CH_0:CH_9]: begin
        tok_o.kind  = TK_DIGIT;
        tok_o.digit = 4'(char_i.character - CH_0);
      end
      CH_MINUS:     tok_o.kind = TK_MINUS;
      CH_DOT:       tok_o.kind = TK_DOT;
      CH_G:         tok_o.kind = TK_G;
      CH_X:         tok_o.kind = TK_X;
      CH_Y:         tok_o.kind = TK_Y;
      default:      tok_o.kind = TK_OTHER;
    endcase
  end

  assign tok_valid_o  = char_i.valid;
  assign char_i.ready = tok_ready_i;

endmodule

>>> src/gmlp_queue.sv
// ----------------------------------------------------------------------------
// gmlp_queue
// Short token queue between the classifier and the line assembler.
// ----------------------------------------------------------------------------
module gmlp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  input  gmlp_pkg::token_t  wr_tok_i,
  output logic              wr_ready_o,
  output logic              rd_valid_o,
  output gmlp_pkg::token_t  rd_tok_o,
  input  logic              rd_ready_i
);
  import gmlp_pkg::*;

  token_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              wr_fire, rd_fire;

  assign wr_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_tok_o   = mem_q[rptr_q];
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (wr_fire) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_fire) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCNT_W'(wr_fire) - QCNT_W'(rd_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wptr_q] <= wr_tok_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_fire && !rd_fire) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not grow on write");

endmodule

>>> src/gmlp_back.sv
// ----------------------------------------------------------------------------
// gmlp_back
// Word state machine, fixed-point accumulate and line assembly; registered
// result output.
// ----------------------------------------------------------------------------
module gmlp_back #(
  parameter int unsigned FRAC_DIGITS = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_valid_i,
  input  gmlp_pkg::token_t  tok_i,
  output logic              tok_ready_o,
  gmlp_cmd_if.source        cmd_o
);
  import gmlp_pkg::*;

  localparam int unsigned FCW = $clog2(FRAC_DIGITS + 1);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_G          = 3'd1;
  localparam logic [2:0] PH_AXIS_START = 3'd2;
  localparam logic [2:0] PH_INT        = 3'd3;
  localparam logic [2:0] PH_FRAC       = 3'd4;

  logic [2:0]       phase_q, phase_d;
  logic [6:0]       g_q, g_d;
  logic [MAG_W-1:0] acc_q, acc_d;
  logic             is_y_q, is_y_d;
  logic             neg_q, neg_d;
  logic [FCW-1:0]   fcnt_q, fcnt_d;
  logic [1:0]       ltype_q, ltype_d;
  logic             lunk_q, lunk_d;
  logic [31:0]      lx_q, lx_d, ly_q, ly_d;
  logic             lxok_q, lxok_d, lyok_q, lyok_d;
  logic [31:0]      px_q, px_d, py_q, py_d;
  logic             pxok_q, pxok_d, pyok_q, pyok_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       o_type_q, o_type_d;
  logic             o_unk_q, o_unk_d;
  logic [31:0]      o_x_q, o_x_d, o_y_q, o_y_d;
  logic             o_xok_q, o_xok_d, o_yok_q, o_yok_d;
  logic             load_out;

  logic             tok_fire, is_digit;
  logic [10:0]      g_sum;
  logic [6:0]       g_sat;
  logic [POW_W+3:0] int_inc, frac_inc;
  logic [35:0]      int_sum;
  logic [31:0]      frac_sum;
  logic [MAG_W-1:0] int_sat, frac_sat;
  logic [2:0]       frac_k;
  logic [31:0]      word_val;
  logic             cont;

  assign tok_ready_o = !(tok_i.kind == TK_EOL && out_valid_q && !cmd_o.ready);
  assign tok_fire    = tok_valid_i && tok_ready_o;
  assign is_digit    = (tok_i.kind == TK_DIGIT);

  assign g_sum = ({4'b0, g_q} << 3) + ({4'b0, g_q} << 1) + 11'(tok_i.digit);
  assign g_sat = (g_sum > 11'(G_MAX)) ? G_MAX : g_sum[6:0];

  assign int_inc  = tok_i.digit * pow10(3'(FRAC_DIGITS));
  assign int_sum  = ({5'b0, acc_q} << 3) + ({5'b0, acc_q} << 1) + 36'(int_inc);
  assign int_sat  = (int_sum > 36'(MAG_MAX)) ? MAG_MAX : int_sum[MAG_W-1:0];
  assign frac_k   = 3'(FRAC_DIGITS - 1) - 3'(fcnt_q);
  assign frac_inc = tok_i.digit * pow10(frac_k);
  assign frac_sum = {1'b0, acc_q} + 32'(frac_inc);
  assign frac_sat = (frac_sum > 32'(MAG_MAX)) ? MAG_MAX : frac_sum[MAG_W-1:0];
  assign word_val = neg_q ? (32'd0 - {1'b0, acc_q}) : {1'b0, acc_q};

  always_comb begin
    phase_d = phase_q;  g_d = g_q;      acc_d = acc_q;
    is_y_d = is_y_q;    neg_d = neg_q;  fcnt_d = fcnt_q;
    ltype_d = ltype_q;  lunk_d = lunk_q;
    lx_d = lx_q;        lxok_d = lxok_q;
    ly_d = ly_q;        lyok_d = lyok_q;
    px_d = px_q;        pxok_d = pxok_q;
    py_d = py_q;        pyok_d = pyok_q;
    o_type_d = o_type_q; o_unk_d = o_unk_q;
    o_x_d = o_x_q;      o_xok_d = o_xok_q;
    o_y_d = o_y_q;      o_yok_d = o_yok_q;
    load_out = 1'b0;
    cont     = 1'b0;

    if (tok_fire) begin
      case (phase_q)
        PH_G: begin
          if (is_digit) begin
            g_d  = g_sat;
            cont = 1'b1;
          end
        end
        PH_AXIS_START: begin
          if (tok_i.kind == TK_MINUS) begin
            neg_d = 1'b1; phase_d = PH_INT; cont = 1'b1;
          end else if (is_digit) begin
            acc_d = int_sat; phase_d = PH_INT; cont = 1'b1;
          end else if (tok_i.kind == TK_DOT) begin
            phase_d = PH_FRAC; cont = 1'b1;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            acc_d = int_sat; cont = 1'b1;
          end else if (tok_i.kind == TK_DOT) begin
            phase_d = PH_FRAC; cont = 1'b1;
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            cont = 1'b1;
            if (fcnt_q < FCW'(FRAC_DIGITS)) begin
              acc_d  = frac_sat;
              fcnt_d = fcnt_q + 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (!cont) begin
        // close the current word
        phase_d = PH_IDLE;
        if (phase_q == PH_G) begin
          if (g_q == G_LINEAR) begin
            ltype_d = CMD_LINEAR;
          end else if (g_q == G_HOME) begin
            ltype_d = CMD_HOME;
          end else begin
            lunk_d = 1'b1;
          end
        end else if (phase_q != PH_IDLE) begin
          if (is_y_q) begin
            ly_d = word_val; lyok_d = 1'b1;
          end else begin
            lx_d = word_val; lxok_d = 1'b1;
          end
        end

        if (tok_i.kind == TK_EOL) begin
          if (ltype_d == CMD_LINEAR) begin
            if (!lxok_d) begin
              lx_d = px_q; lxok_d = pxok_q;
            end
            if (!lyok_d) begin
              ly_d = py_q; lyok_d = pyok_q;
            end
          end
          load_out = 1'b1;
          o_type_d = ltype_d;  o_unk_d = lunk_d;
          o_x_d    = lx_d;     o_xok_d = lxok_d;
          o_y_d    = ly_d;     o_yok_d = lyok_d;
          px_d     = lx_d;     pxok_d  = lxok_d;
          py_d     = ly_d;     pyok_d  = lyok_d;
          ltype_d  = CMD_NONE; lunk_d  = 1'b0;
          lx_d     = '0;       lxok_d  = 1'b0;
          ly_d     = '0;       lyok_d  = 1'b0;
        end else if (tok_i.kind == TK_G) begin
          phase_d = PH_G;
          g_d     = '0;
        end else if (tok_i.kind == TK_X || tok_i.kind == TK_Y) begin
          phase_d = PH_AXIS_START;
          is_y_d  = (tok_i.kind == TK_Y);
          acc_d   = '0;
          neg_d   = 1'b0;
          fcnt_d  = '0;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (cmd_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; g_q <= '0; acc_q <= '0;
      is_y_q <= 1'b0; neg_q <= 1'b0; fcnt_q <= '0;
      ltype_q <= CMD_NONE; lunk_q <= 1'b0;
      lx_q <= '0; lxok_q <= 1'b0; ly_q <= '0; lyok_q <= 1'b0;
      px_q <= '0; pxok_q <= 1'b0; py_q <= '0; pyok_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d; g_q <= g_d; acc_q <= acc_d;
      is_y_q <= is_y_d; neg_q <= neg_d; fcnt_q <= fcnt_d;
      ltype_q <= ltype_d; lunk_q <= lunk_d;
      lx_q <= lx_d; lxok_q <= lxok_d; ly_q <= ly_d; lyok_q <= lyok_d;
      px_q <= px_d; pxok_q <= pxok_d; py_q <= py_d; pyok_q <= pyok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_type_q <= o_type_d; o_unk_q <= o_unk_d;
      o_x_q    <= o_x_d;    o_xok_q <= o_xok_d;
      o_y_q    <= o_y_d;    o_yok_q <= o_yok_d;
    end
  end

  assign cmd_o.valid        = out_valid_q;
  assign cmd_o.command_type = o_type_q;
  assign cmd_o.unknown_g    = o_unk_q;
  assign cmd_o.x_position   = o_x_q;
  assign cmd_o.x_present    = o_xok_q;
  assign cmd_o.y_position   = o_y_q;
  assign cmd_o.y_present    = o_yok_q;

  a_result_from_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(tok_fire && tok_i.kind == TK_EOL))
    else $error("result without line end");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (!o_xok_q || !o_yok_q)) |->
      ((o_xok_q || o_x_q == '0) && (o_yok_q || o_y_q == '0)))
    else $error("absent axis carries a value");

  a_fcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= FCW'(FRAC_DIGITS))
    else $error("fraction count overrun");

  a_line_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (ltype_q == CMD_NONE && !lunk_q && !lxok_q && !lyok_q))
    else $error("line state not cleared after result");

endmodule

>>> src/gcode_move_line_parser.sv
// ----------------------------------------------------------------------------
// gcode_move_line_parser
// Streams ASCII G-code characters in and gives one move command per line.
// ----------------------------------------------------------------------------
// One character is accepted every clock cycle, sustained while results are
// taken; the rate is set by the word state machine in the back end, which
// does the multiply-by-ten accumulate of a digit. A character passes the
// classifier into a two-entry token queue, and the result for a line is
// loaded into the output register when its zero byte, read from the queue,
// is taken by the back end. While a result waits to be taken, characters keep
// flowing into the queue until a further line end reaches the back end; the
// queue then fills and the input stalls. Coordinates are signed
// 10^-FRAC_DIGITS units, saturated to +/-2147483647.
module gcode_move_line_parser #(
  parameter int unsigned FRAC_DIGITS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gmlp_char_if.sink   char_i,
  gmlp_cmd_if.source  cmd_o
);
  import gmlp_pkg::*;

  logic   f_valid, f_ready;
  token_t f_tok;
  logic   b_valid, b_ready;
  token_t b_tok;

  gmlp_front u_front (
    .char_i      (char_i),
    .tok_valid_o (f_valid),
    .tok_o       (f_tok),
    .tok_ready_i (f_ready)
  );

  gmlp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_tok_i   (f_tok),
    .wr_ready_o (f_ready),
    .rd_valid_o (b_valid),
    .rd_tok_o   (b_tok),
    .rd_ready_i (b_ready)
  );

  gmlp_back #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (b_valid),
    .tok_i       (b_tok),
    .tok_ready_o (b_ready),
    .cmd_o       (cmd_o)
  );

endmodule

>>> verif/tb_gcode_move_line_parser.sv
// ----------------------------------------------------------------------------
// tb_gcode_move_line_parser
// Feeds G-code lines one character per transfer and checks every command
// result: a directed table with typed results first, then random lines of
// G, X and Y words and noise against a line parser kept in the testbench,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_gcode_move_line_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import gmlp_pkg::*;

  localparam int unsigned FRAC_DIGITS = 3;
  localparam longint unsigned FRAC_SCALE = 10 ** FRAC_DIGITS;
  localparam int ITEMS = 900;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef enum logic [2:0] {W_IDLE, W_G, W_AXIS, W_INT, W_FRAC} word_phase_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               unk;
    logic signed [31:0] x;
    logic               xp;
    logic signed [31:0] y;
    logic               yp;
  } cmd_res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    cmd_res_t   want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  gmlp_char_if char_bus ();
  gmlp_cmd_if  cmd_bus ();

  gcode_move_line_parser #(.FRAC_DIGITS(FRAC_DIGITS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_bus),
    .cmd_o  (cmd_bus)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // parser state
  word_phase_e        phase_m  = W_IDLE;
  logic [6:0]         gnum_m   = '0;
  logic [30:0]        mag_m    = '0;
  bit                 axis_y_m = 1'b0;
  bit                 neg_m    = 1'b0;
  int unsigned        fdig_m   = 0;
  logic [1:0]         ln_type  = CMD_NONE;
  bit                 ln_unk   = 1'b0;
  logic signed [31:0] ln_x     = '0;
  logic signed [31:0] ln_y     = '0;
  bit                 ln_xp    = 1'b0;
  bit                 ln_yp    = 1'b0;
  logic signed [31:0] prv_x    = '0;
  logic signed [31:0] prv_y    = '0;
  bit                 prv_xp   = 1'b0;
  bit                 prv_yp   = 1'b0;

  cmd_res_t pending_cmds[$];
  cmd_res_t typed_cmds[$];
  int       fails        = 0;
  int       chars_sent   = 0;
  int       stall_cycles = 0;
  bit       quiet        = 1'b0;
  bit       idle_mode    = 1'b1;

  dir_row_t dir_rows [27] = '{
    '{CH_NUL, 1'b1, '{CMD_NONE, 1'b0, 32'sd0, 1'b0, 32'sd0, 1'b0}},
    '{CH_G, 1'b0, '0}, '{8'h32, 1'b0, '0}, '{8'h38, 1'b0, '0},
    '{CH_G, 1'b0, '0}, '{8'h35, 1'b0, '0},
    '{CH_Y, 1'b0, '0}, '{CH_DOT, 1'b0, '0}, '{8'h31, 1'b0, '0},
    '{8'h32, 1'b0, '0}, '{8'h33, 1'b0, '0}, '{8'h34, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{CH_NUL, 1'b1, '{CMD_HOME, 1'b1, 32'sd0, 1'b0, 32'sd123, 1'b1}},
    '{CH_G, 1'b0, '0}, '{8'h31, 1'b0, '0},
    // both axes come from the line before
    '{CH_NUL, 1'b1, '{CMD_LINEAR, 1'b0, 32'sd0, 1'b0, 32'sd123, 1'b1}},
    '{CH_X, 1'b0, '0}, '{CH_MINUS, 1'b0, '0},
    '{8'h39, 1'b0, '0}, '{8'h39, 1'b0, '0}, '{8'h39, 1'b0, '0},
    '{8'h39, 1'b0, '0}, '{8'h39, 1'b0, '0}, '{8'h39, 1'b0, '0},
    '{8'h39, 1'b0, '0},
    '{CH_NUL, 1'b1, '{CMD_NONE, 1'b0, -32'sd2147483647, 1'b1, 32'sd0, 1'b0}}
  };

  task automatic parse_char(input logic [7:0] c, output bit line_end, output cmd_res_t res);
    bit                 is_dig;
    bit                 cont;
    logic [3:0]         d;
    longint unsigned    acc;
    longint unsigned    pw;
    logic signed [31:0] val;
    is_dig   = (c >= CH_0) && (c <= CH_9);
    d        = is_dig ? 4'(c - CH_0) : 4'd0;
    cont     = 1'b0;
    line_end = 1'b0;
    res      = '0;
    case (phase_m)
      W_G: begin
        if (is_dig) begin
          acc    = longint'(gnum_m) * 10 + longint'(d);
          gnum_m = (acc > G_MAX) ? G_MAX : 7'(acc);
          cont   = 1'b1;
        end
      end
      W_AXIS, W_INT: begin
        if (phase_m == W_AXIS && c == CH_MINUS) begin
          neg_m   = 1'b1;
          phase_m = W_INT;
          cont    = 1'b1;
        end else if (is_dig) begin
          acc     = longint'(mag_m) * 10 + longint'(d) * FRAC_SCALE;
          mag_m   = (acc > MAG_MAX) ? MAG_MAX : 31'(acc);
          phase_m = W_INT;
          cont    = 1'b1;
        end else if (c == CH_DOT) begin
          phase_m = W_FRAC;
          cont    = 1'b1;
        end
      end
      W_FRAC: begin
        if (is_dig) begin
          if (fdig_m < FRAC_DIGITS) begin
            pw = 1;
            repeat (FRAC_DIGITS - 1 - fdig_m) pw = pw * 10;
            acc    = longint'(mag_m) + longint'(d) * pw;
            mag_m  = (acc > MAG_MAX) ? MAG_MAX : 31'(acc);
            fdig_m = fdig_m + 1;
          end
          cont = 1'b1;
        end
      end
      default: ;
    endcase
    if (cont) return;

    // word end
    case (phase_m)
      W_IDLE: ;
      W_G: begin
        if (gnum_m == G_LINEAR) ln_type = CMD_LINEAR;
        else if (gnum_m == G_HOME) ln_type = CMD_HOME;
        else ln_unk = 1'b1;
      end
      default: begin
        val = neg_m ? -$signed({1'b0, mag_m}) : $signed({1'b0, mag_m});
        if (axis_y_m) begin
          ln_y  = val;
          ln_yp = 1'b1;
        end else begin
          ln_x  = val;
          ln_xp = 1'b1;
        end
      end
    endcase
    phase_m = W_IDLE;

    if (c == CH_NUL) begin
      if (ln_type == CMD_LINEAR) begin
        if (!ln_xp) begin
          ln_x  = prv_x;
          ln_xp = prv_xp;
        end
        if (!ln_yp) begin
          ln_y  = prv_y;
          ln_yp = prv_yp;
        end
      end
      res.cmd  = ln_type;
      res.unk  = ln_unk;
      res.x    = ln_xp ? ln_x : '0;
      res.xp   = ln_xp;
      res.y    = ln_yp ? ln_y : '0;
      res.yp   = ln_yp;
      prv_x    = res.x;
      prv_xp   = ln_xp;
      prv_y    = res.y;
      prv_yp   = ln_yp;
      ln_type  = CMD_NONE;
      ln_unk   = 1'b0;
      ln_x     = '0;
      ln_xp    = 1'b0;
      ln_y     = '0;
      ln_yp    = 1'b0;
      line_end = 1'b1;
    end else if (c == CH_G) begin
      phase_m = W_G;
      gnum_m  = '0;
    end else if (c == CH_X || c == CH_Y) begin
      phase_m  = W_AXIS;
      axis_y_m = (c == CH_Y);
      mag_m    = '0;
      neg_m    = 1'b0;
      fdig_m   = 0;
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    if (chars_sent % 64 == 0) idle_mode = ($urandom_range(0, 3) != 0);
    if (!quiet && idle_mode && $urandom_range(0, 3) == 0) begin
      char_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.character <= c;
    do @(posedge clk_i); while (!char_bus.ready);
    chars_sent = chars_sent + 1;
  endtask

  task automatic make_line(ref logic [7:0] q[$]);
    string num;
    int    n_int;
    q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(1, 255)));
      return;
    end
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          q.push_back(CH_G);
          case ($urandom_range(0, 5))
            0, 1: num = "1";
            2: num = "28";
            3: num = "028";
            4: num = $sformatf("%0d", $urandom_range(0, 2000));
            default: num = "";
          endcase
          foreach (num[i]) q.push_back(num[i]);
        end
        3, 4, 5, 6, 7: begin
          q.push_back($urandom_range(0, 1) ? CH_Y : CH_X);
          if ($urandom_range(0, 2) == 0) q.push_back(CH_MINUS);
          n_int = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 4);
          repeat (n_int) q.push_back(CH_0 + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 1) != 0) begin
            q.push_back(CH_DOT);
            repeat ($urandom_range(0, 5)) q.push_back(CH_0 + 8'($urandom_range(0, 9)));
          end
        end
        8: q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        default: begin
          case ($urandom_range(0, 2))
            0: q.push_back(CH_MINUS);
            1: q.push_back(CH_DOT);
            default: q.push_back(8'($urandom_range(1, 255)));
          endcase
        end
      endcase
      if ($urandom_range(0, 2) == 0) q.push_back(CH_SP);
    end
  endtask

  // predict on input transfers, check output transfers, watch for stalls
  always @(posedge clk_i) begin
    bit       ended;
    cmd_res_t res;
    cmd_res_t got;
    cmd_res_t want;
    if (char_bus.valid && char_bus.ready) begin
      parse_char(char_bus.character, ended, res);
      if (ended) begin
        if (typed_cmds.size() != 0) pending_cmds.push_back(typed_cmds.pop_front());
        else pending_cmds.push_back(res);
      end
    end
    if (cmd_bus.valid && cmd_bus.ready) begin
      got = '{cmd_bus.command_type, cmd_bus.unknown_g, cmd_bus.x_position,
              cmd_bus.x_present, cmd_bus.y_position, cmd_bus.y_present};
      if (pending_cmds.size() == 0) begin
        fails = fails + 1;
        if (fails <= 10)
          $display("unexpected result: type=%0d unk=%0d x=%0d/%0d y=%0d/%0d",
                   got.cmd, got.unk, got.x, got.xp, got.y, got.yp);
      end else begin
        want = pending_cmds.pop_front();
        if (got.cmd !== want.cmd || got.unk !== want.unk || got.x !== want.x ||
            got.xp !== want.xp || got.y !== want.y || got.yp !== want.yp) begin
          fails = fails + 1;
          if (fails <= 10)
            $display({"mismatch: exp type=%0d unk=%0d x=%0d/%0d y=%0d/%0d,",
                      " got type=%0d unk=%0d x=%0d/%0d y=%0d/%0d"},
                     want.cmd, want.unk, want.x, want.xp, want.y, want.yp,
                     got.cmd, got.unk, got.x, got.xp, got.y, got.yp);
        end
      end
    end
    if ((char_bus.valid && char_bus.ready) || (cmd_bus.valid && cmd_bus.ready) || !rst_ni)
      stall_cycles = 0;
    else
      stall_cycles = stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb_gcode_move_line_parser NOT OK");
      $finish;
    end
  end

  // receiver: short random stalls, one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held && chars_sent >= HOLD_CYCLES) begin
        held = 1'b1;
        cmd_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && idle_mode && $urandom_range(0, 4) == 0) begin
        cmd_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      cmd_bus.ready <= 1'b1;
    end
  end

  initial begin
    logic [7:0] line_chars[$];
    char_bus.valid     = 1'b0;
    char_bus.character = '0;
    cmd_bus.ready      = 1'b0;
    rst_ni             = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) typed_cmds.push_back(dir_rows[i].want);
      send_char(dir_rows[i].ch);
    end

    while (chars_sent < ITEMS) begin
      quiet = (chars_sent > ITEMS - 120);
      make_line(line_chars);
      foreach (line_chars[i]) send_char(line_chars[i]);
      send_char(CH_NUL);
    end
    char_bus.valid <= 1'b0;

    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fails == 0)
      $display("tb_gcode_move_line_parser OK");
    else
      $display("tb_gcode_move_line_parser NOT OK");
    $finish;
  end

endmodule
